// ===== hw/rtl/cad_pkg.sv =====
// Shared constants and types for the contact-area-difference score block.
package cad_pkg;

   localparam int AREA_WIDTH_DEFAULT  = 24;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int SUM_WIDTH   = 40;
   localparam int FRAC_BITS   = 16;
   localparam int SCORE_WIDTH = 17;
   localparam int NUM_WIDTH   = SUM_WIDTH + SCORE_WIDTH;
   localparam int CNT_WIDTH   = $clog2(SCORE_WIDTH);

   localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = {SUM_WIDTH{1'b1}};
   localparam logic [SCORE_WIDTH-1:0] SCORE_ONE = SCORE_WIDTH'(1 << FRAC_BITS);

   typedef enum logic [1:0] {
      BK_ACCUM,
      BK_PREP,
      BK_DIVIDE,
      BK_DELIVER
   } back_state_type;

endpackage

// ===== hw/rtl/cad_req_if.sv =====
// Input channel: one pair of contact areas per transfer.
interface cad_req_if #(
   parameter int AREA_WIDTH = 24
);
   logic                  valid;
   logic                  ready;
   logic [AREA_WIDTH-1:0] area_a;
   logic [AREA_WIDTH-1:0] area_b;
   logic                  last_element;

   modport source (output valid, output area_a, output area_b, output last_element,
                   input ready);
   modport sink   (input valid, input area_a, input area_b, input last_element,
                   output ready);
endinterface

// ===== hw/rtl/cad_rsp_if.sv =====
// Result channel: one score per vector.
interface cad_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] score;
   logic        empty_total;
   logic        sum_saturated;

   modport source (output valid, output score, output empty_total, output sum_saturated,
                   input ready);
   modport sink   (input valid, input score, input empty_total, input sum_saturated,
                   output ready);
endinterface

// ===== hw/rtl/cad_front.sv =====
// Front end: holds the mode register and forms the reference and clipped difference.
module cad_front #(
   parameter int AREA_WIDTH = cad_pkg::AREA_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   cad_req_if.sink                 req,
   output logic                    push_valid,
   input  logic                    push_ready,
   output logic [2*AREA_WIDTH:0]   push_data
);
   import cad_pkg::*;

   logic                  symmetric_mode_ff, symmetric_mode_in;
   logic [AREA_WIDTH-1:0] larger, abs_diff, reference, diff_clip;

   always_comb begin
      symmetric_mode_in = symmetric_mode_ff;
      if (csr_write_enable) begin
         symmetric_mode_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symmetric_mode_ff <= 1'b1;
      end else begin
         symmetric_mode_ff <= symmetric_mode_in;
      end
   end

   always_comb begin
      larger    = (req.area_a > req.area_b) ? req.area_a : req.area_b;
      abs_diff  = (req.area_a > req.area_b) ? (req.area_a - req.area_b)
                                            : (req.area_b - req.area_a);
      reference = symmetric_mode_ff ? larger : req.area_a;
      diff_clip = (abs_diff > reference) ? reference : abs_diff;
   end

   assign push_valid = req.valid;
   assign req.ready  = push_ready;
   assign push_data  = {reference, diff_clip, req.last_element};

endmodule

// ===== hw/rtl/cad_queue.sv =====
// Small register FIFO between the front and back ends.
module cad_queue #(
   parameter int WIDTH = 49,
   parameter int DEPTH = cad_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != CNT_WIDTH'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/cad_back.sv =====
// Back end: saturating sums, restoring divider and the result register.
module cad_back #(
   parameter int AREA_WIDTH = cad_pkg::AREA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  logic [2*AREA_WIDTH:0] pop_data,
   cad_rsp_if.source             rsp
);
   import cad_pkg::*;

   back_state_type         state_ff, state_in;
   logic [SUM_WIDTH-1:0]   dsum_ff, dsum_in, rsum_ff, rsum_in;
   logic                   sat_ff, sat_in;
   logic [SUM_WIDTH-1:0]   fin_d_ff, fin_d_in, den_ff, den_in;
   logic                   fin_sat_ff, fin_sat_in;
   logic                   empty_ff, empty_in;
   logic [SUM_WIDTH-1:0]   rem_ff, rem_in;
   logic [SCORE_WIDTH-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SCORE_WIDTH-1:0] score_ff, score_in;
   logic                   empty_out_ff, empty_out_in, sat_out_ff, sat_out_in;

   logic [AREA_WIDTH-1:0]  item_ref, item_diff;
   logic                   item_last;
   logic [SUM_WIDTH:0]     dsum_add, rsum_add;
   logic [SUM_WIDTH-1:0]   dsum_next, rsum_next;
   logic                   sat_next;
   logic [NUM_WIDTH-1:0]   numerator;
   logic [SUM_WIDTH:0]     trial;
   logic                   quo_bit, load_out;

   assign {item_ref, item_diff, item_last} = pop_data;

   always_comb begin
      dsum_add  = {1'b0, dsum_ff} + (SUM_WIDTH + 1)'(item_diff);
      rsum_add  = {1'b0, rsum_ff} + (SUM_WIDTH + 1)'(item_ref);
      dsum_next = dsum_add[SUM_WIDTH] ? SUM_MAX : dsum_add[SUM_WIDTH-1:0];
      rsum_next = rsum_add[SUM_WIDTH] ? SUM_MAX : rsum_add[SUM_WIDTH-1:0];
      sat_next  = sat_ff || dsum_add[SUM_WIDTH] || rsum_add[SUM_WIDTH];
      numerator = {1'b0, fin_d_ff, FRAC_BITS'(0)} + NUM_WIDTH'(den_ff >> 1);
      trial     = {rem_ff, num_ff[SCORE_WIDTH-1]};
      quo_bit   = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      state_in     = state_ff;
      dsum_in      = dsum_ff;
      rsum_in      = rsum_ff;
      sat_in       = sat_ff;
      fin_d_in     = fin_d_ff;
      den_in       = den_ff;
      fin_sat_in   = fin_sat_ff;
      empty_in     = empty_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      pop_ready    = 1'b0;
      load_out     = 1'b0;
      score_in     = score_ff;
      empty_out_in = empty_out_ff;
      sat_out_in   = sat_out_ff;

      unique case (state_ff)
         BK_ACCUM: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               if (item_last) begin
                  fin_d_in   = dsum_next;
                  den_in     = rsum_next;
                  fin_sat_in = sat_next;
                  dsum_in    = '0;
                  rsum_in    = '0;
                  sat_in     = 1'b0;
                  state_in   = BK_PREP;
               end else begin
                  dsum_in = dsum_next;
                  rsum_in = rsum_next;
                  sat_in  = sat_next;
               end
            end
         end
         BK_PREP: begin
            empty_in = (den_ff == '0);
            rem_in   = numerator[NUM_WIDTH-1:SCORE_WIDTH];
            num_in   = numerator[SCORE_WIDTH-1:0];
            quo_in   = '0;
            cnt_in   = CNT_WIDTH'(SCORE_WIDTH - 1);
            state_in = (den_ff == '0) ? BK_DELIVER : BK_DIVIDE;
         end
         BK_DIVIDE: begin
            rem_in = quo_bit ? SUM_WIDTH'(trial - {1'b0, den_ff}) : trial[SUM_WIDTH-1:0];
            quo_in = {quo_ff[SCORE_WIDTH-2:0], quo_bit};
            num_in = {num_ff[SCORE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = BK_DELIVER;
            end
         end
         BK_DELIVER: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_out     = 1'b1;
               score_in     = (empty_ff || quo_ff >= SCORE_ONE) ? '0 : SCORE_ONE - quo_ff;
               empty_out_in = empty_ff;
               sat_out_in   = fin_sat_ff;
               state_in     = BK_ACCUM;
            end
         end
         default: state_in = BK_ACCUM;
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_ACCUM;
         dsum_ff      <= '0;
         rsum_ff      <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dsum_ff      <= dsum_in;
         rsum_ff      <= rsum_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_d_ff     <= fin_d_in;
      den_ff       <= den_in;
      fin_sat_ff   <= fin_sat_in;
      empty_ff     <= empty_in;
      rem_ff       <= rem_in;
      num_ff       <= num_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      score_ff     <= score_in;
      empty_out_ff <= empty_out_in;
      sat_out_ff   <= sat_out_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.score         = score_ff;
   assign rsp.empty_total   = empty_out_ff;
   assign rsp.sum_saturated = sat_out_ff;

endmodule

// ===== hw/rtl/cad_score_vector_compare_top.sv =====
// Top level of the contact-area-difference score block.
//
// Streams two vectors of contact areas, one element pair per transfer on req_if,
// and returns one Q1.16 score per vector on rsp_if after the transfer marked
// last_element. Areas are unsigned fixed point with 8 fraction bits. Each pair
// gives a reference (the larger area when csr_write_data last wrote 1, the
// default after reset, otherwise area_a) and a difference |a - b| clipped to
// that reference; both feed 40-bit saturating sums. The score is
// 65536 - round(diff_sum * 65536 / ref_sum); a zero reference sum gives score 0
// with empty_total set, and sum_saturated flags a clipped sum in that vector.
// Rate: the front end takes one pair per cycle into a QUEUE_DEPTH-entry queue
// while it has room; the back end drains one pair per cycle while accumulating.
// A last pair holds the back end through a setup step, a 17-step restoring
// divider retiring one quotient bit per cycle, and a delivery step waiting
// for a free result register; the queue lets the next vector start arriving
// during the divide. Write the mode only while no vector is in flight.
module cad_score_vector_compare_top #(
   parameter int AREA_WIDTH  = cad_pkg::AREA_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = cad_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   cad_req_if.sink  req_if,
   cad_rsp_if.source rsp_if,
   input  logic     csr_write_enable,
   input  logic     csr_write_data
);
   import cad_pkg::*;

   localparam int ITEM_WIDTH = 2 * AREA_WIDTH + 1;

   // Classified pairs: {reference, clipped difference, last}.
   logic                  q_push_valid, q_push_ready;
   logic [ITEM_WIDTH-1:0] q_push_data;
   logic                  q_pop_valid, q_pop_ready;
   logic [ITEM_WIDTH-1:0] q_pop_data;

   cad_front #(
      .AREA_WIDTH (AREA_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_if),
      .push_valid       (q_push_valid),
      .push_ready       (q_push_ready),
      .push_data        (q_push_data)
   );

   cad_queue #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   cad_back #(
      .AREA_WIDTH (AREA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_data  (q_pop_data),
      .rsp       (rsp_if)
   );

   // Back end must stop draining once it takes the last pair of a vector.
   a_stop_after_last: assert property (@(posedge clock) disable iff (reset)
      q_pop_valid && q_pop_ready && q_pop_data[0] |=> !q_pop_ready)
      else $error("back end kept draining after a last pair");

   // A new result is loaded only from the delivery step, never while draining.
   a_load_not_draining: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> !$past(q_pop_ready))
      else $error("result loaded while the back end was draining");

   // An empty total always reports a zero score.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.empty_total |-> rsp_if.score == '0)
      else $error("empty total with nonzero score");

   // Score never exceeds one.
   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.score <= SCORE_ONE)
      else $error("score above one");

endmodule

// ===== tb/tb_cad_score_vector_compare_top.sv =====
// Self-checking testbench for the contact-area-difference score block.
module tb_cad_score_vector_compare_top;

   import cad_pkg::*;

   localparam int AREA_W = AREA_WIDTH_DEFAULT;
   localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

   // Mode register values.
   localparam bit MODE_FIRST     = 1'b0;
   localparam bit MODE_SYMMETRIC = 1'b1;

   // Cycles to let pass after the last result before touching the mode:
   // covers a setup step, the 17 divide steps and the delivery step, with margin.
   localparam int SETTLE_CYCLES  = 25;
   // Cycles with no transfer on either channel before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 2000;
   // Length of the one long receiver hold-off.
   localparam int RSP_HOLD_CYCLES = 300;
   // Pairs per random phase and in the quiet tail.
   localparam int PHASE_ITEMS = 350;
   localparam int TAIL_ITEMS  = 150;

   typedef struct packed {
      logic [SCORE_WIDTH-1:0] score;
      logic                   empty_total;
      logic                   sum_saturated;
   } score_result_t;

   // Running contact-area-difference sums and the scores they lead to.
   class cad_score_checker;
      bit                   symmetric;
      logic [SUM_WIDTH-1:0] diff_total;
      logic [SUM_WIDTH-1:0] ref_total;
      bit                   clipped;
      score_result_t        score_q[$];
      int unsigned          mismatches;

      function new();
         symmetric  = MODE_SYMMETRIC;
         diff_total = '0;
         ref_total  = '0;
         clipped    = 1'b0;
         mismatches = 0;
      endfunction

      function int pending();
         return score_q.size();
      endfunction

      function logic [SUM_WIDTH-1:0] add_clip(logic [SUM_WIDTH-1:0] acc,
                                              logic [AREA_W-1:0] term);
         logic [SUM_WIDTH:0] wide;
         wide = {1'b0, acc} + (SUM_WIDTH+1)'(term);
         if (wide > (SUM_WIDTH+1)'(SUM_MAX)) begin
            clipped = 1'b1;
            return SUM_MAX;
         end
         return wide[SUM_WIDTH-1:0];
      endfunction

      // Fold one accepted pair into the sums; a last pair yields one score.
      function void note_pair(logic [AREA_W-1:0] a, logic [AREA_W-1:0] b, bit last);
         logic [AREA_W-1:0] ref_term;
         logic [AREA_W-1:0] diff_term;
         logic [63:0]       num;
         logic [63:0]       quo;
         score_result_t     res;
         if (symmetric) ref_term = (a > b) ? a : b;
         else           ref_term = a;
         diff_term = (a > b) ? (a - b) : (b - a);
         if (diff_term > ref_term) diff_term = ref_term;
         diff_total = add_clip(diff_total, diff_term);
         ref_total  = add_clip(ref_total, ref_term);
         if (!last) return;
         if (ref_total == '0) begin
            res.score       = '0;
            res.empty_total = 1'b1;
         end else begin
            num = (64'(diff_total) << FRAC_BITS) + (64'(ref_total) >> 1);
            quo = num / 64'(ref_total);
            res.score = (quo >= 64'(SCORE_ONE)) ? '0 : (SCORE_ONE - SCORE_WIDTH'(quo));
            res.empty_total = 1'b0;
         end
         res.sum_saturated = clipped;
         score_q.push_back(res);
         diff_total = '0;
         ref_total  = '0;
         clipped    = 1'b0;
      endfunction

      task report_mismatch(string what, int unsigned got, int unsigned want);
         $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
         mismatches++;
      endtask

      task check_score(score_result_t got);
         score_result_t want;
         if (score_q.size() == 0) begin
            report_mismatch("unexpected score transfer", got.score, 0);
            return;
         end
         want = score_q.pop_front();
         if (got.score !== want.score)
            report_mismatch("score", got.score, want.score);
         if (got.empty_total !== want.empty_total)
            report_mismatch("empty_total", got.empty_total, want.empty_total);
         if (got.sum_saturated !== want.sum_saturated)
            report_mismatch("sum_saturated", got.sum_saturated, want.sum_saturated);
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   cad_req_if #(.AREA_WIDTH(AREA_W)) req_bus ();
   cad_rsp_if                        rsp_bus ();

   cad_score_checker scoreboard;

   // Set by the stimulus to ask the receiver for its long hold-off.
   bit rsp_stall_request = 1'b0;
   // Set for the last part of the run: no idling on either side.
   bit quiet_tail = 1'b0;

   cad_score_vector_compare_top #(.AREA_WIDTH(AREA_W)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sample both channels at the edge; every value read here was settled by
   // the previous edge, so event order within the step does not matter.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         scoreboard.note_pair(req_bus.area_a, req_bus.area_b, req_bus.last_element);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         scoreboard.check_score({rsp_bus.score, rsp_bus.empty_total,
                                 rsp_bus.sum_saturated});
   end

   // Abort when neither channel has moved a transfer for too long.
   int unsigned stuck_cycles = 0;
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: random stalls, one long hold-off on request, always ready
   // once the quiet tail starts. One assignment per edge.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stall_request) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall_request = 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 3)) @(posedge clock);
         end
      end
   end

   // Offer one pair and hold it until the transfer; then drop valid for a
   // gap if one is asked. A following pair is raised in the same step.
   task automatic send_pair(input logic [AREA_W-1:0] a, input logic [AREA_W-1:0] b,
                            input bit last, input int gap);
      req_bus.valid        <= 1'b1;
      req_bus.area_a       <= a;
      req_bus.area_b       <= b;
      req_bus.last_element <= last;
      do @(posedge clock); while (!req_bus.ready);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering, wait for every score, then let the divider settle.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the mode register; only called with nothing in flight.
   task automatic write_mode(input bit mode);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      scoreboard.symmetric = mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [AREA_W-1:0] pick_area();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return AREA_MAX;
         2:       return AREA_W'($urandom_range(0, 255));
         3:       return AREA_W'($urandom_range(0, 65535));
         default: return AREA_W'($urandom());
      endcase
   endfunction

   // One vector of random pairs, mostly short; now and then a long one,
   // one with every first area zero, or one streamed without gaps.
   task automatic send_random_vector(output int sent);
      int                len;
      bit                zero_vec;
      bit                no_gaps;
      int                gap;
      logic [AREA_W-1:0] a;
      logic [AREA_W-1:0] b;
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      zero_vec = ($urandom_range(0, 19) == 0);
      no_gaps  = quiet_tail || ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
         a = pick_area();
         case ($urandom_range(0, 3))
            0:       b = a;
            1:       b = a + AREA_W'($urandom_range(0, 31)) - AREA_W'(16);
            default: b = pick_area();
         endcase
         if (zero_vec) begin
            a = '0;
            if ($urandom_range(0, 1) == 0) b = '0;
         end
         gap = 0;
         if (!no_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
         send_pair(a, b, i == len - 1, gap);
      end
      sent = len;
   endtask

   initial begin
      int sent;
      int phase_items;

      scoreboard           = new();
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_write_data       = 1'b0;
      req_bus.valid        = 1'b0;
      req_bus.area_a       = '0;
      req_bus.area_b       = '0;
      req_bus.last_element = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, symmetric mode from reset: empty total, identical full-scale
      // areas, one-sided areas, a two-pair vector, a tiny difference.
      send_pair('0, '0, 1'b1, 0);
      send_pair(AREA_MAX, AREA_MAX, 1'b1, 1);
      send_pair(AREA_MAX, '0, 1'b1, 0);
      send_pair('0, AREA_MAX, 1'b1, 2);
      send_pair(24'h000100, 24'h000180, 1'b0, 0);
      send_pair(24'h000080, 24'h000080, 1'b1, 0);
      send_pair(24'h000001, '0, 1'b1, 0);
      send_pair(24'hAAAAAA, 24'h555555, 1'b1, 0);
      drain_results();

      // Directed, first-area mode: a zero first area gives an empty total,
      // a difference larger than the first area is clipped to it.
      write_mode(MODE_FIRST);
      send_pair('0, AREA_MAX, 1'b1, 0);
      send_pair(24'h000100, 24'hFFFF00, 1'b1, 0);
      send_pair(AREA_MAX, '0, 1'b1, 3);
      send_pair(24'h555555, 24'hAAAAAA, 1'b0, 0);
      send_pair(24'hAAAAAA, 24'h555555, 1'b0, 0);
      send_pair(24'h123456, 24'h123456, 1'b1, 0);
      send_pair('0, '0, 1'b0, 0);
      send_pair('0, 24'h000005, 1'b0, 0);
      send_pair(24'h800000, 24'h7FFFFF, 1'b1, 0);
      // 1/3 exercises rounding of the quotient.
      send_pair(24'h000003, 24'h000002, 1'b1, 0);
      drain_results();

      // Random phases, alternating the mode; the third one starts with the
      // receiver holding off so the block backs up and stalls the sender.
      for (int phase = 0; phase < 4; phase++) begin
         write_mode((phase % 2 == 0) ? MODE_SYMMETRIC : MODE_FIRST);
         if (phase == 2) rsp_stall_request = 1'b1;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            send_random_vector(sent);
            phase_items += sent;
            if ($urandom_range(0, 39) == 0) drain_results();
         end
         drain_results();
      end

      // Quiet tail: random vectors streamed back to back, receiver always ready.
      quiet_tail = 1'b1;
      write_mode(MODE_SYMMETRIC);
      phase_items = 0;
      while (phase_items < TAIL_ITEMS) begin
         send_random_vector(sent);
         phase_items += sent;
      end
      drain_results();

      if (scoreboard.pending() != 0)
         scoreboard.report_mismatch("scores never delivered", 0, scoreboard.pending());
      if (scoreboard.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
